>>> src/bfr_pkg.sv
// types and constants shared by the bitmap font text renderer
// no dependencies; imported by bitmap_font_text_renderer_unit
package bfr_pkg;

    // register map, word index in the apb space
    localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROW_PITCH    = 2'd1;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;
    localparam logic [1:0] REG_FONT_VALID   = 2'd3;

    localparam logic       ACTION_DRAW = 1'b0;
    localparam logic       ACTION_LOAD = 1'b1;

    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;

    localparam int         CELL_WIDTH = 8;

    localparam logic [12:0] WRAP_MIN = 13'd8;
    localparam logic [12:0] WRAP_MAX = 13'd4096;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [31:0] draw_color;
        logic [4:0]  load_row_index;
        logic [7:0]  load_row_bits;
    } bfr_cmd_t;

    typedef struct packed {
        logic [31:0] pixel_index;
        logic [11:0] row_x;
        logic [16:0] row_y;
        logic [7:0]  pixel_mask;
        logic [31:0] pixel_color;
        logic        last_row;
    } bfr_row_t;

endpackage

>>> src/bitmap_font_text_renderer_unit.sv
// Text console renderer: an 8-pixel-wide glyph store, a cursor and one row sequencer.
// A load request writes a glyph row; a draw request yields framebuffer row writes.
// Depends on bfr_pkg for the request and result types and register codes.
// A load, a newline, an ignored character and a glyph of zero height are handled in S_IDLE.
// A drawn character or a backspace passes S_MUL, which forms cursor_row * pitch, and
// S_ADD, which adds the column; then S_ROWS issues N rows, N being the glyph height
// (capped at MAX_GLYPH_ROWS) or CELL_HEIGHT for an erase, one row per cycle while
// results are taken at once, the glyph store read port prefetching the next row while the
// shared adder steps the pixel index by the row pitch. A stalled result register
// stalls the sequencer. cmd_ready is high only between characters. The glyph store
// has no reset; glyphs must be loaded before they are drawn.
module bitmap_font_text_renderer_unit #(
    parameter int GLYPH_COUNT    = 256,
    parameter int MAX_GLYPH_ROWS = 32,
    parameter int CELL_HEIGHT    = 16
) (
    input  logic            clk,
    input  logic            rst_n,

    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  bfr_pkg::bfr_cmd_t cmd,

    output logic            row_valid,
    input  logic            row_ready,
    output bfr_pkg::bfr_row_t row,

    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import bfr_pkg::*;

    localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int MAX_ROWS    = (MAX_GLYPH_ROWS > CELL_HEIGHT) ? MAX_GLYPH_ROWS : CELL_HEIGHT;
    localparam int CW          = $clog2(MAX_ROWS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_ROWS = 2'd3;

    // configuration
    logic [12:0] screen_width_reg;
    logic [13:0] row_pitch_reg;
    logic [5:0]  glyph_height_reg;
    logic        font_valid_reg;

    // control and cursor
    logic [1:0]  state_reg, state_next;
    logic [11:0] col_reg, col_next;
    logic [15:0] crow_reg, crow_next;
    logic [CW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] rows_total_reg, rows_total_next;
    logic        row_valid_reg, row_valid_next;

    // per-character payload
    logic [7:0]  code_reg, code_next;
    logic [31:0] color_reg, color_next;
    logic        erase_reg, erase_next;
    logic        code_ok_reg, code_ok_next;
    logic [31:0] idx_reg, idx_next;
    bfr_row_t    row_reg, row_next;

    // glyph store
    logic [7:0]  store_mem [STORE_DEPTH];
    logic [7:0]  rdata_reg;
    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] rd_row;

    // datapath helpers
    logic        cfg_write;
    logic [12:0] wrap_w;
    logic [12:0] col_plus;
    logic [16:0] nl_sum;
    logic [15:0] nl_row;
    logic [31:0] addend, add_sum;
    logic        advance, is_last;
    logic [5:0]  glyph_rows;
    logic        cmd_take;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg <= 13'd1024;
            row_pitch_reg    <= 14'd1024;
            glyph_height_reg <= 6'd16;
            font_valid_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SCREEN_WIDTH: screen_width_reg <= pwdata[12:0];
                REG_ROW_PITCH:    row_pitch_reg    <= pwdata[13:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[5:0];
                REG_FONT_VALID:   font_valid_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SCREEN_WIDTH: prdata = {19'd0, screen_width_reg};
            REG_ROW_PITCH:    prdata = {18'd0, row_pitch_reg};
            REG_GLYPH_HEIGHT: prdata = {26'd0, glyph_height_reg};
            REG_FONT_VALID:   prdata = {31'd0, font_valid_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- cursor arithmetic ----------------
    always_comb
    begin
        if (screen_width_reg < WRAP_MIN)
            wrap_w = WRAP_MIN;
        else if (screen_width_reg > WRAP_MAX)
            wrap_w = WRAP_MAX;
        else
            wrap_w = screen_width_reg;
    end

    assign col_plus = {1'b0, col_reg} + 13'(CELL_WIDTH);
    assign nl_sum   = {1'b0, crow_reg} + 17'(CELL_HEIGHT);
    assign nl_row   = nl_sum[16] ? 16'hFFFF : nl_sum[15:0];

    assign glyph_rows = (glyph_height_reg > 6'(MAX_GLYPH_ROWS)) ?
                        6'(MAX_GLYPH_ROWS) : glyph_height_reg;

    // shared adder: adds the column once, then steps by the pitch per row
    assign addend  = (state_reg == S_ADD) ? {20'd0, col_reg} : {18'd0, row_pitch_reg};
    assign add_sum = idx_reg + addend;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_take  = cmd_valid && cmd_ready;
    assign advance   = !row_valid_reg || row_ready;
    assign is_last   = (row_cnt_reg + CW'(1)) == rows_total_reg;

    // ---------------- glyph store ports ----------------
    assign wr_en   = cmd_take && (cmd.action == ACTION_LOAD)
                     && (32'(cmd.char_code) < GLYPH_COUNT)
                     && (32'(cmd.load_row_index) < MAX_GLYPH_ROWS);
    assign wr_addr = AW'(cmd.char_code) * AW'(MAX_GLYPH_ROWS) + AW'(cmd.load_row_index);

    assign rd_row  = (state_reg == S_MUL) ? '0 : row_cnt_reg + CW'(1);
    assign rd_addr = AW'(code_reg) * AW'(MAX_GLYPH_ROWS) + AW'(rd_row);
    assign rd_en   = !erase_reg && code_ok_reg
                     && ((state_reg == S_MUL)
                         || ((state_reg == S_ROWS) && advance && !is_last));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= cmd.load_row_bits;
        if (rd_en)
            rdata_reg <= store_mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        crow_next       = crow_reg;
        row_cnt_next    = row_cnt_reg;
        rows_total_next = rows_total_reg;
        row_valid_next  = row_valid_reg;
        code_next       = code_reg;
        color_next      = color_reg;
        erase_next      = erase_reg;
        code_ok_next    = code_ok_reg;
        idx_next        = idx_reg;
        row_next        = row_reg;

        if (row_valid_reg && row_ready)
            row_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take && (cmd.action == ACTION_DRAW))
                begin
                    code_next    = cmd.char_code;
                    color_next   = cmd.draw_color;
                    code_ok_next = 32'(cmd.char_code) < GLYPH_COUNT;
                    row_cnt_next = '0;
                    if (cmd.char_code == CODE_NEWLINE)
                    begin
                        col_next  = '0;
                        crow_next = nl_row;
                    end
                    else if (cmd.char_code == CODE_BACKSPACE)
                    begin
                        if (col_reg >= 12'(CELL_WIDTH))
                            col_next = col_reg - 12'(CELL_WIDTH);
                        else if (crow_reg >= 16'(CELL_HEIGHT))
                        begin
                            col_next  = 12'(wrap_w - 13'(CELL_WIDTH));
                            crow_next = crow_reg - 16'(CELL_HEIGHT);
                        end
                        erase_next      = 1'b1;
                        rows_total_next = CW'(CELL_HEIGHT);
                        state_next      = S_MUL;
                    end
                    else if (font_valid_reg)
                    begin
                        erase_next      = 1'b0;
                        rows_total_next = CW'(glyph_rows);
                        if (glyph_rows == 6'd0)
                        begin
                            // nothing to draw, only the cursor moves
                            if (col_plus >= wrap_w)
                            begin
                                col_next  = '0;
                                crow_next = nl_row;
                            end
                            else
                                col_next = col_plus[11:0];
                        end
                        else
                            state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                idx_next   = 32'(crow_reg * row_pitch_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                idx_next   = add_sum;
                state_next = S_ROWS;
            end
            S_ROWS:
            begin
                if (advance)
                begin
                    row_valid_next       = 1'b1;
                    row_next.pixel_index = idx_reg;
                    row_next.row_x       = col_reg;
                    row_next.row_y       = {1'b0, crow_reg} + 17'(row_cnt_reg);
                    row_next.pixel_mask  = erase_reg ? 8'hFF :
                                           (code_ok_reg ? rdata_reg : 8'h00);
                    row_next.pixel_color = erase_reg ? 32'd0 : color_reg;
                    row_next.last_row    = is_last;
                    idx_next             = add_sum;
                    row_cnt_next         = row_cnt_reg + CW'(1);
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                        if (!erase_reg)
                        begin
                            if (col_plus >= wrap_w)
                            begin
                                col_next  = '0;
                                crow_next = nl_row;
                            end
                            else
                                col_next = col_plus[11:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_reg        <= '0;
            crow_reg       <= '0;
            row_cnt_reg    <= '0;
            rows_total_reg <= '0;
            row_valid_reg  <= 1'b0;
            erase_reg      <= 1'b0;
            code_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            crow_reg       <= crow_next;
            row_cnt_reg    <= row_cnt_next;
            rows_total_reg <= rows_total_next;
            row_valid_reg  <= row_valid_next;
            erase_reg      <= erase_next;
            code_ok_reg    <= code_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        color_reg <= color_next;
        idx_reg   <= idx_next;
        row_reg   <= row_next;
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

    // ---------------- checks ----------------
    a_rows_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWS) |-> (rows_total_reg != '0))
        else $error("row sequence started with zero rows");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWS) |-> (row_cnt_reg < rows_total_reg))
        else $error("row counter ran past the row total");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ROWS) && advance && is_last) |=>
            ((state_reg == S_IDLE) && row_valid_reg && row_reg.last_row))
        else $error("last row did not end the character");

    a_setup_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_ADD))
        else $error("index setup skipped the column add");

endmodule

>>> verif/tb_bitmap_font_text_renderer_unit.sv
`timescale 1ns / 1ps
// self-checking bench for bitmap_font_text_renderer_unit: random and directed requests,
// rows predicted by an in-bench cursor and glyph store model; depends on bfr_pkg
module tb_bitmap_font_text_renderer_unit;
    import bfr_pkg::*;

    localparam int GLYPHS        = 256;
    localparam int GLYPH_ROWS    = 32;
    localparam int CELL_H        = 16;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    bfr_cmd_t    cmd       = '0;
    logic        row_valid;
    logic        row_ready = 1'b0;
    bfr_row_t    row;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers and the cursor
    logic [12:0] cfg_width  = 13'd1024;
    logic [13:0] cfg_pitch  = 14'd1024;
    logic [5:0]  cfg_height = 6'd16;
    logic        cfg_valid  = 1'b1;
    logic [11:0] cur_col    = '0;
    logic [15:0] cur_row    = '0;
    logic [7:0]  glyph_rows [0:GLYPHS*GLYPH_ROWS-1];

    bit          glyph_loaded [0:GLYPHS*GLYPH_ROWS-1];
    bfr_cmd_t    queued_requests [$];
    bfr_row_t    due_rows [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          pressure_armed = 1'b0;
    bit          pressure_done;
    int          hold_left;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    bitmap_font_text_renderer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int wrap_px();
        if (cfg_width < WRAP_MIN)
            return WRAP_MIN;
        if (cfg_width > WRAP_MAX)
            return WRAP_MAX;
        return cfg_width;
    endfunction

    function automatic void line_feed();
        cur_col = '0;
        if (cur_row > 16'hFFFF - CELL_H)
            cur_row = 16'hFFFF;
        else
            cur_row = 16'(cur_row + CELL_H);
    endfunction

    function automatic void push_row(int r, logic [7:0] mask, logic [31:0] color, logic last);
        bfr_row_t  e;
        longint    y;
        y = longint'(cur_row) + r;
        e.pixel_index = 32'(y * longint'(cfg_pitch) + longint'(cur_col));
        e.row_x       = cur_col;
        e.row_y       = 17'(y);
        e.pixel_mask  = mask;
        e.pixel_color = color;
        e.last_row    = last;
        due_rows.push_back(e);
    endfunction

    // expected rows and cursor update for one accepted request
    function automatic void render_request(bfr_cmd_t c);
        int n;
        int r;
        if (c.action == ACTION_LOAD)
            glyph_rows[{c.char_code, c.load_row_index}] = c.load_row_bits;
        else if (c.char_code == CODE_NEWLINE)
            line_feed();
        else if (c.char_code == CODE_BACKSPACE)
        begin
            if (cur_col >= CELL_WIDTH)
                cur_col = 12'(cur_col - CELL_WIDTH);
            else if (cur_row >= CELL_H)
            begin
                cur_col = 12'(wrap_px() - CELL_WIDTH);
                cur_row = 16'(cur_row - CELL_H);
            end
            for (r = 0; r < CELL_H; r++)
                push_row(r, 8'hFF, 32'h0, r == CELL_H - 1);
        end
        else if (cfg_valid)
        begin
            n = (cfg_height > GLYPH_ROWS) ? GLYPH_ROWS : int'(cfg_height);
            for (r = 0; r < n; r++)
                push_row(r, glyph_rows[{c.char_code, 5'(r)}], c.draw_color, r == n - 1);
            if (int'(cur_col) + CELL_WIDTH >= wrap_px())
                line_feed();
            else
                cur_col = 12'(cur_col + CELL_WIDTH);
        end
    endfunction

    function automatic void field_mismatch(string name, logic [31:0] e, logic [31:0] a);
        $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
        mismatch_count++;
    endfunction

    function automatic void compare_row(bfr_row_t e, bfr_row_t a);
        if (e.pixel_index !== a.pixel_index)
            field_mismatch("pixel_index", e.pixel_index, a.pixel_index);
        if (e.row_x !== a.row_x)
            field_mismatch("row_x", e.row_x, a.row_x);
        if (e.row_y !== a.row_y)
            field_mismatch("row_y", e.row_y, a.row_y);
        if (e.pixel_mask !== a.pixel_mask)
            field_mismatch("pixel_mask", e.pixel_mask, a.pixel_mask);
        if (e.pixel_color !== a.pixel_color)
            field_mismatch("pixel_color", e.pixel_color, a.pixel_color);
        if (e.last_row !== a.last_row)
            field_mismatch("last_row", e.last_row, a.last_row);
    endfunction

    function automatic void queue_load(logic [7:0] code, logic [4:0] idx, logic [7:0] bits);
        bfr_cmd_t c;
        c.action         = ACTION_LOAD;
        c.char_code      = code;
        c.draw_color     = $urandom();
        c.load_row_index = idx;
        c.load_row_bits  = bits;
        queued_requests.push_back(c);
        glyph_loaded[{code, idx}] = 1'b1;
    endfunction

    // a drawn glyph gets its missing rows loaded first, so no unwritten row is read
    function automatic void queue_draw(logic [7:0] code, logic [31:0] color);
        bfr_cmd_t c;
        int       n;
        int       r;
        n = (cfg_height > GLYPH_ROWS) ? GLYPH_ROWS : int'(cfg_height);
        if (cfg_valid && code != CODE_NEWLINE && code != CODE_BACKSPACE)
        begin
            for (r = 0; r < n; r++)
                if (!glyph_loaded[{code, 5'(r)}])
                    queue_load(code, 5'(r), 8'($urandom()));
        end
        c.action         = ACTION_DRAW;
        c.char_code      = code;
        c.draw_color     = color;
        c.load_row_index = 5'($urandom());
        c.load_row_bits  = 8'($urandom());
        queued_requests.push_back(c);
    endfunction

    function automatic void queue_random(int count);
        int i;
        int pick;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                queue_draw(8'(8'h41 + $urandom_range(3)), $urandom());
            else if (pick < 62)
                queue_draw(CODE_NEWLINE, $urandom());
            else if (pick < 76)
                queue_draw(CODE_BACKSPACE, $urandom());
            else if (pick < 88)
                queue_load(8'($urandom_range(255)), 5'($urandom_range(31)),
                           8'($urandom_range(255)));
            else
                queue_draw(8'($urandom_range(255)), $urandom());
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [12:0] w, logic [13:0] p, logic [5:0] h, logic v);
        write_reg(REG_SCREEN_WIDTH, 32'(w));
        write_reg(REG_ROW_PITCH, 32'(p));
        write_reg(REG_GLYPH_HEIGHT, 32'(h));
        write_reg(REG_FONT_VALID, 32'(v));
        cfg_width  = w;
        cfg_pitch  = p;
        cfg_height = h;
        cfg_valid  = v;
    endtask

    task automatic drain();
        while (queued_requests.size() != 0 || cmd_valid || due_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_ready)
        begin
            if (cmd_valid)
                render_request(cmd);
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd       <= queued_requests.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result side ready, with one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ready     <= 1'b0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            row_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (pressure_armed && !pressure_done)
        begin
            row_ready     <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else
            row_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && row_valid && row_ready)
        begin
            if (due_rows.size() == 0)
            begin
                $display("%0t: row result expected none actual %h", $time, row);
                mismatch_count++;
            end
            else
                compare_row(due_rows.pop_front(), row);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("bitmap_font_text_renderer_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: backspace at origin, wrap back to the previous line, a glyph
        queue_draw(CODE_BACKSPACE, $urandom());
        queue_draw(CODE_NEWLINE, $urandom());
        queue_draw(CODE_BACKSPACE, $urandom());
        queue_draw(8'h00, 32'h0000_0000);
        queue_draw(8'h00, 32'hFFFF_FFFF);
        queue_draw(CODE_BACKSPACE, $urandom());
        queue_load(8'hFF, 5'd31, 8'hFF);
        drain();

        // narrowest screen, a pitch of eight, one-row glyphs
        set_config(13'd8, 14'd8, 6'd1, 1'b1);
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        queue_random(15);
        drain();

        // widest screen, tallest glyphs, a pitch of 8192; leave the column well inside the line
        set_config(13'd4096, 14'd8192, 6'd32, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        queue_draw(CODE_BACKSPACE, $urandom());
        queue_draw(CODE_BACKSPACE, $urandom());
        queue_draw(CODE_NEWLINE, $urandom());
        repeat (3) queue_draw(8'h41, $urandom());
        drain();

        // width below range, so the column is already past it; zero pitch and height
        set_config(13'd3, 14'd0, 6'd0, 1'b1);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        queue_random(15);
        drain();

        // width and height above range, font marked invalid
        set_config(13'd8191, 14'd16383, 6'd63, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(15);
        drain();

        // long result stall while requests keep coming
        set_config(13'd200, 14'd1000, 6'd9, 1'b1);
        pressure_armed = 1'b1;
        queue_random(12);
        drain();

        // run the cursor down several lines, then keep drawing there
        set_config(13'd1024, 14'd640, 6'd9, 1'b1);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        repeat (10) queue_draw(CODE_NEWLINE, $urandom());
        queue_random(10);
        drain();

        if (mismatch_count == 0)
            $display("bitmap_font_text_renderer_unit: match");
        else
            $display("bitmap_font_text_renderer_unit: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
src/bfr_pkg.sv
src/bitmap_font_text_renderer_unit.sv
verif/tb_bitmap_font_text_renderer_unit.sv
